>>> hdl/uart_pkg.sv
package uart_pkg;

  // data bits per frame, 5 to 9
  localparam int unsigned DATA_BITS = 8;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TIMER_W  = PERIOD_W + 1;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd103;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [TIMER_W-1:0]  timer_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  localparam count_t DATA_BITS_C = COUNT_W'(DATA_BITS);
  localparam count_t BYTE_BITS_C = COUNT_W'(BYTE_W);

endpackage

>>> hdl/uart_8n1_transceiver.sv
// tick-driven serial receiver and transmitter, one input transfer per time tick
// latency: the result of a tick is shown in the cycle after its input transfer
// throughput: one tick per cycle while the result register is drained, set by the single registered state update
// in_ready stays high while the result register is empty or being drained
// reset (rst, synchronous): both sides idle, timers and shifters clear,
// line_out high (the tx_line output is not reset), bit period 103, result register empty
module uart_8n1_transceiver (
  input  logic             clk,
  input  logic             rst,
  // tick channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             rx_line,
  input  logic             tx_valid,
  input  uart_pkg::byte_t  tx_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             tx_line,
  output logic             tx_ready,
  output logic             rx_valid,
  output uart_pkg::byte_t  rx_byte,
  // bit period register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  uart_pkg::period_t cfg_data
);
  import uart_pkg::*;

  // configuration
  period_t bit_period;

  // receiver state
  phase_t  rx_phase, rx_phase_next;
  timer_t  rx_timer, rx_timer_next;
  count_t  rx_bits_done, rx_bits_done_next;
  byte_t   rx_shift, rx_shift_next;

  // transmitter state
  phase_t  tx_phase, tx_phase_next;
  timer_t  tx_timer, tx_timer_next;
  count_t  tx_bits_done, tx_bits_done_next;
  byte_t   tx_shift, tx_shift_next;
  logic    line_out, line_out_next;

  // result of this tick
  logic    rx_valid_next;
  byte_t   rx_byte_next;
  logic    tx_ready_next;

  logic    in_fire;
  period_t period_ticks;
  timer_t  period_half;
  timer_t  period_two;
  timer_t  rx_dec;
  timer_t  tx_dec;

  assign cfg_ready = 1'b1;
  // a new tick is taken whenever the result register is empty or frees up this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // zero period acts as one tick
  assign period_ticks = (bit_period == '0) ? PERIOD_W'(1) : bit_period;
  assign period_half  = {1'b0, period_ticks} + {2'b00, period_ticks[PERIOD_W-1:1]};
  assign period_two   = {period_ticks, 1'b0};

  // timers saturate at zero
  assign rx_dec = (rx_timer == '0) ? '0 : rx_timer - TIMER_W'(1);
  assign tx_dec = (tx_timer == '0) ? '0 : tx_timer - TIMER_W'(1);

  // receiver: start detect, mid-bit sampling, stop wait
  always_comb begin
    rx_phase_next     = rx_phase;
    rx_timer_next     = rx_timer;
    rx_bits_done_next = rx_bits_done;
    rx_shift_next     = rx_shift;
    rx_valid_next     = 1'b0;
    rx_byte_next      = '0;
    unique case (rx_phase)
      PH_IDLE: begin
        if (!rx_line) begin
          rx_phase_next     = PH_DATA;
          rx_timer_next     = period_half;
          rx_bits_done_next = '0;
          rx_shift_next     = '0;
        end
      end
      PH_DATA: begin
        rx_timer_next = rx_dec;
        if (rx_dec == '0) begin
          // bits past the eighth are dropped
          if (rx_bits_done < BYTE_BITS_C) begin
            rx_shift_next[rx_bits_done[2:0]] = rx_shift[rx_bits_done[2:0]] | rx_line;
          end
          rx_bits_done_next = rx_bits_done + COUNT_W'(1);
          if (rx_bits_done_next >= DATA_BITS_C) begin
            rx_valid_next = 1'b1;
            rx_byte_next  = rx_shift_next;
            rx_phase_next = PH_STOP;
            rx_timer_next = period_half;
          end else begin
            rx_timer_next = {1'b0, period_ticks};
          end
        end
      end
      PH_STOP: begin
        rx_timer_next = rx_dec;
        if (rx_dec == '0) begin
          rx_phase_next = PH_IDLE;
        end
      end
      default: begin
        rx_phase_next = PH_IDLE;
      end
    endcase
  end

  // transmitter: start bit, data bits, two bit periods of stop
  always_comb begin
    tx_phase_next     = tx_phase;
    tx_timer_next     = tx_timer;
    tx_bits_done_next = tx_bits_done;
    tx_shift_next     = tx_shift;
    line_out_next     = line_out;
    tx_ready_next     = (tx_phase == PH_IDLE);
    unique case (tx_phase)
      PH_IDLE: begin
        if (tx_valid) begin
          tx_phase_next     = PH_DATA;
          tx_shift_next     = tx_byte;
          tx_bits_done_next = '0;
          tx_timer_next     = {1'b0, period_ticks};
          line_out_next     = 1'b0;
        end
      end
      PH_DATA: begin
        tx_timer_next = tx_dec;
        if (tx_dec == '0) begin
          if (tx_bits_done < DATA_BITS_C) begin
            // ninth bit goes out low
            line_out_next     = (tx_bits_done < BYTE_BITS_C) ?
                                tx_shift[tx_bits_done[2:0]] : 1'b0;
            tx_bits_done_next = tx_bits_done + COUNT_W'(1);
            tx_timer_next     = {1'b0, period_ticks};
          end else if (tx_bits_done == DATA_BITS_C) begin
            line_out_next     = 1'b1;
            tx_bits_done_next = tx_bits_done + COUNT_W'(1);
            tx_timer_next     = period_two;
          end else begin
            line_out_next = 1'b1;
            tx_phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        tx_phase_next = PH_IDLE;
        line_out_next = 1'b1;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bit_period <= cfg_data;
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= PH_IDLE;
      rx_timer     <= '0;
      rx_bits_done <= '0;
      rx_shift     <= '0;
      tx_phase     <= PH_IDLE;
      tx_timer     <= '0;
      tx_bits_done <= '0;
      tx_shift     <= '0;
      line_out     <= 1'b1;
    end else if (in_fire) begin
      rx_phase     <= rx_phase_next;
      rx_timer     <= rx_timer_next;
      rx_bits_done <= rx_bits_done_next;
      rx_shift     <= rx_shift_next;
      tx_phase     <= tx_phase_next;
      tx_timer     <= tx_timer_next;
      tx_bits_done <= tx_bits_done_next;
      tx_shift     <= tx_shift_next;
      line_out     <= line_out_next;
    end
  end

  // result register, filled on each tick transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_line  <= line_out_next;
      tx_ready <= tx_ready_next;
      rx_valid <= rx_valid_next;
      rx_byte  <= rx_byte_next;
    end
  end

  // start bit seen while idle arms the receiver with a running timer
  assert property (@(posedge clk) disable iff (rst)
    in_fire && rx_phase == PH_IDLE && !rx_line |=> rx_phase == PH_DATA && rx_timer != '0)
    else $error("receiver did not arm on start bit");

  // a completed byte moves the receiver to its stop wait and shows in the result
  assert property (@(posedge clk) disable iff (rst)
    in_fire && rx_valid_next |=> rx_phase == PH_STOP && out_valid && rx_valid)
    else $error("received byte not reported with stop wait");

  // an accepted send request drives the start bit on the next result,
  // which still reports the transmitter as ready on that tick
  assert property (@(posedge clk) disable iff (rst)
    in_fire && tx_phase == PH_IDLE && tx_valid |=> out_valid && !tx_line && tx_ready
      && tx_phase == PH_DATA)
    else $error("send request did not start a frame");

  // receiver never reports a byte outside its data phase
  assert property (@(posedge clk) disable iff (rst)
    in_fire && rx_phase != PH_DATA |-> !rx_valid_next)
    else $error("byte reported outside data phase");

endmodule

>>> verif/uart_8n1_transceiver_tb.sv
`timescale 1ns / 1ps

module uart_8n1_transceiver_tb;
  import uart_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic  rx_line;
    logic  tx_valid;
    byte_t tx_byte;
  } tick_in_t;

  typedef struct packed {
    logic  tx_line;
    logic  tx_ready;
    logic  rx_valid;
    byte_t rx_byte;
  } tick_out_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  logic    rx_line = 1'b1;
  logic    tx_valid = 1'b0;
  byte_t   tx_byte = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    tx_line;
  logic    tx_ready;
  logic    rx_valid;
  byte_t   rx_byte;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  period_t cfg_data = '0;

  uart_8n1_transceiver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_line   (rx_line),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_line   (tx_line),
    .tx_ready  (tx_ready),
    .rx_valid  (rx_valid),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ticks waiting to be driven, and results the block owes us
  tick_in_t  pending_ticks[$];
  tick_out_t expected_outputs[$];

  bit          idle_on = 1'b1;
  bit          tick_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  // shadow copy of the transceiver state
  period_t line_period = PERIOD_RESET;
  phase_t  rx_ph = PH_IDLE;
  timer_t  rx_tmr = '0;
  count_t  rx_cnt = '0;
  logic [8:0] rx_sh = '0;
  phase_t  tx_ph = PH_IDLE;
  timer_t  tx_tmr = '0;
  count_t  tx_cnt = '0;
  byte_t   tx_sh = '0;
  logic    line_q = 1'b1;

  // one tick of both halves, returns the levels seen after the tick
  function automatic tick_out_t run_uart_tick(tick_in_t t);
    tick_out_t r;
    timer_t    bit_ticks;
    timer_t    bit_and_half;
    // a zero period behaves as one tick per bit
    bit_ticks = (line_period == '0) ? timer_t'(1) : timer_t'(line_period);
    bit_and_half = bit_ticks + (bit_ticks >> 1);
    r.tx_ready = (tx_ph == PH_IDLE);
    r.rx_valid = 1'b0;
    r.rx_byte = '0;

    // receiver: start bit, then samples in the middle of each data bit
    case (rx_ph)
      PH_IDLE: begin
        if (!t.rx_line) begin
          rx_ph = PH_DATA;
          rx_tmr = bit_and_half;
          rx_cnt = '0;
          rx_sh = '0;
        end
      end
      PH_DATA: begin
        if (rx_tmr != '0) rx_tmr = rx_tmr - 1'b1;
        if (rx_tmr == '0) begin
          // a ninth data bit lands above the byte and is dropped
          if (rx_cnt <= BYTE_BITS_C) rx_sh[rx_cnt] = t.rx_line;
          rx_cnt = rx_cnt + 1'b1;
          if (rx_cnt >= DATA_BITS_C) begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_sh[BYTE_W-1:0];
            rx_ph = PH_STOP;
            rx_tmr = bit_and_half;
          end else begin
            rx_tmr = bit_ticks;
          end
        end
      end
      default: begin
        // stop wait, the tick it runs out only goes back to idle
        if (rx_tmr != '0) rx_tmr = rx_tmr - 1'b1;
        if (rx_tmr == '0) rx_ph = PH_IDLE;
      end
    endcase

    // transmitter: start bit, data bits, two bit times of stop
    if (tx_ph == PH_IDLE) begin
      if (t.tx_valid) begin
        tx_ph = PH_DATA;
        tx_sh = t.tx_byte;
        tx_cnt = '0;
        tx_tmr = bit_ticks;
        line_q = 1'b0;
      end
    end else begin
      if (tx_tmr != '0) tx_tmr = tx_tmr - 1'b1;
      if (tx_tmr == '0) begin
        if (tx_cnt < DATA_BITS_C) begin
          line_q = (tx_cnt < BYTE_BITS_C) ? tx_sh[tx_cnt[2:0]] : 1'b0;
          tx_cnt = tx_cnt + 1'b1;
          tx_tmr = bit_ticks;
        end else if (tx_cnt == DATA_BITS_C) begin
          line_q = 1'b1;
          tx_cnt = tx_cnt + 1'b1;
          tx_tmr = bit_ticks << 1;
        end else begin
          line_q = 1'b1;
          tx_ph = PH_IDLE;
        end
      end
    end

    r.tx_line = line_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // one tick with the given receive level and a random send request
  function automatic void push_tick(logic level);
    tick_in_t t;
    t.rx_line = level;
    t.tx_valid = ($urandom_range(0, 3) == 0);
    t.tx_byte = byte_t'($urandom_range(0, 255));
    pending_ticks.push_back(t);
  endfunction

  function automatic void push_directed(logic level, logic req, byte_t data);
    tick_in_t t;
    t.rx_line = level;
    t.tx_valid = req;
    t.tx_byte = data;
    pending_ticks.push_back(t);
  endfunction

  // mostly clean frames with random data, with bursts of line noise between
  task automatic queue_line_traffic(period_t p, int unsigned count);
    int unsigned pe;
    int unsigned added;
    int unsigned len;
    logic [9:0]  frame;
    pe = (p == '0) ? 1 : p;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3 * pe);
        repeat (len) push_tick(1'($urandom_range(0, 1)));
        added += len;
      end else begin
        // stop, data lsb first, start
        frame = {1'b1, byte_t'($urandom_range(0, 255)), 1'b0};
        len = $urandom_range(0, 2 * pe);
        repeat (len) push_tick(1'b1);
        added += len;
        for (int b = 0; b < 10; b++) begin
          // the stop bit may end right when the receiver goes idle again
          len = (b == 9) ? pe + $urandom_range(1, pe) : pe;
          repeat (len) push_tick(frame[b]);
          added += len;
        end
      end
    end
  endtask

  // after settling of the falling edge updates, nothing queued or in flight
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_ticks.size() != 0 || in_valid || expected_outputs.size() != 0);
  endtask

  task automatic write_bit_period(period_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // tick driver: holds a tick until its transfer, with random gaps between while idle_on is set
  always @(negedge clk) begin
    tick_in_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        t = pending_ticks.pop_front();
        in_valid <= 1'b1;
        rx_line <= t.rx_line;
        tx_valid <= t.tx_valid;
        tx_byte <= t.tx_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure in bursts while idle_on is set
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (out_stall != 0) begin
      out_stall = out_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      out_stall = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predicts on each tick transfer, checks each result transfer
  always @(posedge clk) begin
    tick_in_t  t;
    tick_out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) line_period = cfg_data;
      tick_taken = in_valid && in_ready;
      if (tick_taken) begin
        t.rx_line = rx_line;
        t.tx_valid = tx_valid;
        t.tx_byte = tx_byte;
        expected_outputs.push_back(run_uart_tick(t));
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h",
                   $time, {tx_line, tx_ready, rx_valid, rx_byte});
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("tx_line", 8'(want.tx_line), 8'(tx_line));
          check_field("tx_ready", 8'(want.tx_ready), 8'(tx_ready));
          check_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid));
          check_field("rx_byte", want.rx_byte, rx_byte);
        end
      end
      if (tick_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog on transfers
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // tiny periods, a zero period, small periods, then the top of the range
    static period_t sweep [10] = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd5, 16'd2, 16'd9,
                                   16'd16, 16'd4, 16'hFFFF};
    // at the reset period: a send starts, busy requests are refused,
    // a start bit arrives, field extremes on both bytes
    push_directed(1'b1, 1'b0, 8'h00);
    push_directed(1'b1, 1'b1, 8'hFF);
    push_directed(1'b1, 1'b1, 8'h00);
    push_directed(1'b0, 1'b1, 8'h5A);
    push_directed(1'b1, 1'b0, 8'hFF);
    push_directed(1'b0, 1'b1, 8'hA5);
    push_directed(1'b1, 1'b0, 8'h00);
    // enough ticks for the first bit time at the reset period to run out
    repeat (160) push_tick(1'($urandom_range(0, 1)));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // each new period may land mid-frame and takes effect at the next reload
    for (int i = 0; i < 10; i++) begin
      idle_on = (i < 8);
      write_bit_period(sweep[i]);
      if (sweep[i] == '1)
        repeat (40) push_tick(1'($urandom_range(0, 1)));
      else
        queue_line_traffic(sweep[i], 190);
      wait_drained();
    end

    // leave room for any stray result
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
hdl/uart_pkg.sv
hdl/uart_8n1_transceiver.sv
verif/uart_8n1_transceiver_tb.sv
